FILE: design/matrix_multiply_engine_macros.svh
// Assertion macros used by the checker file of the matrix multiply engine.
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mme check failed");

// next-cycle implication, disabled while reset is low
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mme check failed");

`endif

FILE: design/mme_pkg.sv
// Types, constants and codes of the matrix multiply engine.
package mme_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int CFG_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W = 2;
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int ACC_W  = PROD_W + IDX_W + 1;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = CFG_W'(8);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (ELEM_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMON_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS     = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

FILE: design/mme_ifs.sv
// Channel interfaces of the matrix multiply engine: input, result and configuration.
interface mme_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [mme_pkg::KIND_W-1:0]             kind;
  logic [mme_pkg::IDX_W-1:0]              row_index;
  logic [mme_pkg::IDX_W-1:0]              col_index;
  logic signed [mme_pkg::ELEM_WIDTH-1:0]  element_value;

  modport source (output valid, kind, row_index, col_index, element_value, input ready);
  modport sink   (input valid, kind, row_index, col_index, element_value, output ready);
endinterface

interface mme_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [mme_pkg::IDX_W-1:0]              result_row;
  logic [mme_pkg::IDX_W-1:0]              result_col;
  logic signed [mme_pkg::ELEM_WIDTH-1:0]  result_value;
  logic                                   last_of_run;

  modport source (output valid, result_row, result_col, result_value, last_of_run,
                  input ready);
  modport sink   (input valid, result_row, result_col, result_value, last_of_run,
                  output ready);
endinterface

interface mme_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mme_pkg::CFG_IDX_W-1:0]   index;
  logic [mme_pkg::CFG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/mme_mac.sv
// Shared multiply-accumulate unit with floor and saturation to the element format.
module mme_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mme_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [mme_pkg::ELEM_WIDTH-1:0] a_i,
  input  logic signed [mme_pkg::ELEM_WIDTH-1:0] b_i,
  output logic                                  busy,
  output logic signed [mme_pkg::ELEM_WIDTH-1:0] result
);

  logic                                  prod_vld_r;
  logic signed [mme_pkg::PROD_W-1:0]     prod_r;
  logic signed [mme_pkg::ACC_W-1:0]      acc_r;
  logic signed [mme_pkg::ACC_W-1:0]      shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      prod_r <= a_i * b_i;
    end
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + {{(mme_pkg::ACC_W - mme_pkg::PROD_W){prod_r[mme_pkg::PROD_W-1]}},
                        prod_r};
    end
  end

  // arithmetic shift gives floor division by 2^FRAC_BITS
  assign shifted = acc_r >>> mme_pkg::FRAC_BITS;
  assign busy    = prod_vld_r;

  always_comb begin
    if (shifted > mme_pkg::SAT_HI) begin
      result = mme_pkg::SAT_HI[mme_pkg::ELEM_WIDTH-1:0];
    end else if (shifted < mme_pkg::SAT_LO) begin
      result = mme_pkg::SAT_LO[mme_pkg::ELEM_WIDTH-1:0];
    end else begin
      result = shifted[mme_pkg::ELEM_WIDTH-1:0];
    end
  end

endmodule

FILE: design/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: element stores, sequencer and result register.
//
// Use: load A and B one element per request on in_ch (kind load A / load B,
// row_index, col_index, element_value). A load leaves the block idle, and it
// is ready again at once. A run request multiplies A (a_rows x common_length)
// by B (common_length x b_cols) and emits one result per product element on
// out_ch, column by column with rows inner; last_of_run marks the final one.
// Sizes come from cfg_ch (index 0 a_rows, 1 common_length, 2 b_cols), values
// above 8 act as 8; cfg_ch is ready out of reset and is to be written by the
// user only while idle, which the block does not enforce. Per product element
// the sequencer issues one store read per step of the dot product through the
// single shared MAC, waits for read register, product register and accumulator
// to drain, then loads the result register; with common_length zero there are
// no reads. A run computes a_rows * b_cols elements with in_ch.ready low for
// all of it; zero rows or columns emit nothing and the run request is consumed.
// Stall: results sit in one output register; while it is full the sequencer
// computes the next element and then waits until the register is taken.
// Reset (rst_n low, synchronous) sets sizes to 8, empties the pipeline and
// the output register, and holds in_ch and cfg_ch not ready. Store contents
// are undefined until written.
module matrix_multiply_engine (
  input  logic          clk,
  input  logic          rst_n,
  mme_in_if.sink        in_ch,
  mme_out_if.source     out_ch,
  mme_cfg_if.sink       cfg_ch
);

  // configuration
  logic [mme_pkg::CFG_W-1:0] a_rows_r, common_len_r, b_cols_r;
  logic [mme_pkg::CNT_W-1:0] rows_c, len_c, cols_c;

  // element stores, one entry per (row, column)
  logic signed [mme_pkg::ELEM_WIDTH-1:0] a_mem [mme_pkg::MAX_DIM * mme_pkg::MAX_DIM];
  logic signed [mme_pkg::ELEM_WIDTH-1:0] b_mem [mme_pkg::MAX_DIM * mme_pkg::MAX_DIM];
  logic signed [mme_pkg::ELEM_WIDTH-1:0] a_rd_r, b_rd_r;
  logic                                  rd_vld_r;
  logic [mme_pkg::ADDR_W-1:0]            wr_addr, a_rd_addr, b_rd_addr;

  // sequencer
  mme_pkg::state_t           state_r, state_nxt;
  logic [mme_pkg::IDX_W-1:0] row_r, col_r, k_r;
  logic                      in_acc, wr_a, wr_b, run_go;
  logic                      row_last, col_last, k_last, len_zero;
  logic                      out_free, emit, run_done, issue, pipe_empty;
  mme_pkg::mac_ctrl_t        mac_ctrl;
  logic                      mac_busy;
  logic signed [mme_pkg::ELEM_WIDTH-1:0] mac_result;

  // result register
  logic                                  out_vld_r;
  logic [mme_pkg::IDX_W-1:0]             out_row_r, out_col_r;
  logic signed [mme_pkg::ELEM_WIDTH-1:0] out_val_r;
  logic                                  out_last_r;

  // ---------------- configuration port ----------------
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r     <= mme_pkg::CFG_DIM_RESET;
      common_len_r <= mme_pkg::CFG_DIM_RESET;
      b_cols_r     <= mme_pkg::CFG_DIM_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        mme_pkg::CFG_A_ROWS:     a_rows_r     <= cfg_ch.data;
        mme_pkg::CFG_COMMON_LEN: common_len_r <= cfg_ch.data;
        mme_pkg::CFG_B_COLS:     b_cols_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sizes above the store bound act as the bound
  assign rows_c = (a_rows_r > mme_pkg::CFG_W'(mme_pkg::MAX_DIM)) ?
                  mme_pkg::CNT_W'(mme_pkg::MAX_DIM) : mme_pkg::CNT_W'(a_rows_r);
  assign len_c  = (common_len_r > mme_pkg::CFG_W'(mme_pkg::MAX_DIM)) ?
                  mme_pkg::CNT_W'(mme_pkg::MAX_DIM) : mme_pkg::CNT_W'(common_len_r);
  assign cols_c = (b_cols_r > mme_pkg::CFG_W'(mme_pkg::MAX_DIM)) ?
                  mme_pkg::CNT_W'(mme_pkg::MAX_DIM) : mme_pkg::CNT_W'(b_cols_r);

  // ---------------- input decode ----------------
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign wr_a    = in_acc && (in_ch.kind == mme_pkg::KIND_LOAD_A);
  assign wr_b    = in_acc && (in_ch.kind == mme_pkg::KIND_LOAD_B);
  // empty product: the run request is simply consumed
  assign run_go  = in_acc && (in_ch.kind == mme_pkg::KIND_RUN) &&
                   (rows_c != '0) && (cols_c != '0);

  assign wr_addr   = mme_pkg::ADDR_W'(in_ch.row_index) * mme_pkg::ADDR_W'(mme_pkg::MAX_DIM)
                   + mme_pkg::ADDR_W'(in_ch.col_index);
  assign a_rd_addr = mme_pkg::ADDR_W'(row_r) * mme_pkg::ADDR_W'(mme_pkg::MAX_DIM)
                   + mme_pkg::ADDR_W'(k_r);
  assign b_rd_addr = mme_pkg::ADDR_W'(k_r) * mme_pkg::ADDR_W'(mme_pkg::MAX_DIM)
                   + mme_pkg::ADDR_W'(col_r);

  // ---------------- stores ----------------
  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_addr] <= in_ch.element_value;
    end
    if (wr_b) begin
      b_mem[wr_addr] <= in_ch.element_value;
    end
    if (issue) begin
      a_rd_r <= a_mem[a_rd_addr];
      b_rd_r <= b_mem[b_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
    end
  end

  // ---------------- shared MAC ----------------
  assign mac_ctrl.valid = rd_vld_r;
  assign mac_ctrl.clear = run_go || (emit && !run_done);

  mme_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .a_i    (a_rd_r),
    .b_i    (b_rd_r),
    .busy   (mac_busy),
    .result (mac_result)
  );

  // ---------------- sequencer ----------------
  assign row_last   = (mme_pkg::CNT_W'(row_r) == rows_c - mme_pkg::CNT_W'(1));
  assign col_last   = (mme_pkg::CNT_W'(col_r) == cols_c - mme_pkg::CNT_W'(1));
  assign k_last     = (mme_pkg::CNT_W'(k_r) == len_c - mme_pkg::CNT_W'(1));
  assign len_zero   = (len_c == '0);
  assign pipe_empty = !rd_vld_r && !mac_busy;
  assign out_free   = !out_vld_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mme_pkg::S_IDLE: begin
        if (run_go) begin
          state_nxt = len_zero ? mme_pkg::S_WAIT : mme_pkg::S_MAC;
        end
      end
      mme_pkg::S_MAC: begin
        if (k_last) begin
          state_nxt = mme_pkg::S_WAIT;
        end
      end
      mme_pkg::S_WAIT: begin
        if (pipe_empty) begin
          state_nxt = mme_pkg::S_EMIT;
        end
      end
      mme_pkg::S_EMIT: begin
        if (out_free) begin
          if (row_last && col_last) begin
            state_nxt = mme_pkg::S_IDLE;
          end else begin
            state_nxt = len_zero ? mme_pkg::S_WAIT : mme_pkg::S_MAC;
          end
        end
      end
      default: state_nxt = mme_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    emit        = 1'b0;
    case (state_r)
      mme_pkg::S_IDLE: in_ch.ready = rst_n;
      mme_pkg::S_MAC:  issue       = 1'b1;
      mme_pkg::S_WAIT: ;
      mme_pkg::S_EMIT: emit        = out_free;
      default: ;
    endcase
  end

  assign run_done = emit && row_last && col_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::S_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (run_go) begin
        row_r <= '0;
        col_r <= '0;
        k_r   <= '0;
      end else begin
        if (issue) begin
          k_r <= k_last ? '0 : k_r + mme_pkg::IDX_W'(1);
        end
        // rows inner, columns outer
        if (emit && !run_done) begin
          if (row_last) begin
            row_r <= '0;
            col_r <= col_r + mme_pkg::IDX_W'(1);
          end else begin
            row_r <= row_r + mme_pkg::IDX_W'(1);
          end
        end
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r  <= row_r;
      out_col_r  <= col_r;
      out_val_r  <= mac_result;
      out_last_r <= row_last && col_last;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_row   = out_row_r;
  assign out_ch.result_col   = out_col_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.last_of_run  = out_last_r;

endmodule

FILE: design/mme_checker.sv
// Port-level checks of the matrix multiply engine and their bind to the top level.
`include "matrix_multiply_engine_macros.svh"

module mme_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [mme_pkg::KIND_W-1:0]   in_kind,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_last
);

  // a waiting result is not withdrawn
  `MME_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a run still in progress keeps the input side closed
  `MME_ASSERT_NOW(a_run_blocks_in, clk, rst_n, out_valid && !out_last, !in_ready)

  // loads never stall the input side
  `MME_ASSERT_NEXT(a_load_keeps_ready, clk, rst_n,
    in_valid && in_ready && (in_kind == mme_pkg::KIND_LOAD_A || in_kind == mme_pkg::KIND_LOAD_B),
    in_ready)

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_kind   (in_ch.kind),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_of_run)
);
